@@ hw/rtl/lru_key_value_cache_core_assert.svh @@
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property shorthands for the cache core checks.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Word types, command codes, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W       = 32;
  localparam int PAY_W       = 64;
  localparam int CFG_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  // request word as seen at the port
  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] lookup_key;
    logic [PAY_W-1:0]        payload_in;
  } req_t;

  // result word as seen at the port
  typedef struct packed {
    logic                    hit;
    logic [PAY_W-1:0]        payload_out;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

  // classified word held in the queue between front and back
  typedef struct packed {
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } q_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_EXEC,
    BK_READ
  } bk_state_e;

endpackage

@@ hw/rtl/lkvc_front.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache front end
// Takes request words, decodes the command, trims the payload and queues them.
// ----------------------------------------------------------------------------
module lkvc_front #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  lkvc_pkg::req_t   req_i,
  output logic             busy,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output lkvc_pkg::q_item_t item_o
);
  import lkvc_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PAY_W-1:0] PayMask = {PAY_W{1'b1}} >> (PAY_W - PAYLOAD_BITS);

  q_item_t           queue_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              push, pop;
  q_item_t           item_new;

  // decode and trim the incoming word
  always_comb begin
    item_new.cmd     = req_i.command ? CMD_PUT : CMD_GET;
    item_new.key     = req_i.lookup_key;
    item_new.payload = req_i.payload_in & PayMask;
  end

  assign busy         = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign push         = start && !busy;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = queue_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

@@ hw/rtl/lkvc_back.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache back end
// Key compare cells, recency ranks, payload memory and the access sequencer.
// ----------------------------------------------------------------------------
module lkvc_back #(
  parameter int ENTRIES      = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  lkvc_pkg::q_item_t           item_i,
  input  logic [lkvc_pkg::CFG_W-1:0]  cap_i,
  output logic                        result_valid_o,
  output lkvc_pkg::rsp_t              rsp_o,
  output logic [$clog2(ENTRIES+1)-1:0] occ_o
);
  import lkvc_pkg::*;

  localparam int IdxW = $clog2(ENTRIES);
  localparam int OccW = $clog2(ENTRIES + 1);
  localparam int CmpW = (OccW > CFG_W) ? OccW : CFG_W;

  bk_state_e             state_q, state_d;
  q_item_t               item_q;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [KEY_W-1:0]      key_q  [ENTRIES];
  logic [IdxW-1:0]       rank_q [ENTRIES];
  logic [IdxW-1:0]       rank_d [ENTRIES];
  logic [OccW-1:0]       occ_q, occ_d;
  logic [ENTRIES-1:0]    hit_vec_q, hit_vec_d;
  logic [ENTRIES-1:0]    vic_vec_q, vic_vec_d;
  logic [PAYLOAD_BITS-1:0] pay_mem [ENTRIES];
  logic [PAYLOAD_BITS-1:0] rd_data_q;
  rsp_t                  res_q, res_d;
  logic                  res_vld_q, res_vld_d;

  logic                  hit_any, need_evict, key_we, pay_we, pay_re;
  logic [IdxW-1:0]       hit_idx, hit_rank, vic_idx, free_idx, ins_idx, pay_idx;
  logic [KEY_W-1:0]      vic_key;
  logic [ENTRIES-1:0]    free_vec, free_oh, ins_oh;
  logic [CmpW-1:0]       cap_ext, eff_cap;
  logic [IdxW-1:0]       lru_rank;

  assign item_ready_o   = (state_q == BK_IDLE);
  assign result_valid_o = res_vld_q;
  assign rsp_o          = res_q;
  assign occ_o          = occ_q;

  // compare cells: key match and least-recent mark, one per entry
  assign lru_rank = IdxW'(occ_q - OccW'(1));
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_d[i] = valid_q[i] && (key_q[i] == item_q.key);
      vic_vec_d[i] = valid_q[i] && (rank_q[i] == lru_rank);
    end
  end

  // one-hot to index folding; keys are unique so hit is at most one-hot
  assign free_vec = ~valid_q;
  assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    vic_idx  = '0;
    vic_key  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_idx  |= IdxW'(i) & {IdxW{hit_vec_q[i]}};
      hit_rank |= rank_q[i] & {IdxW{hit_vec_q[i]}};
      vic_idx  |= IdxW'(i) & {IdxW{vic_vec_q[i]}};
      vic_key  |= key_q[i] & {KEY_W{vic_vec_q[i]}};
      free_idx |= IdxW'(i) & {IdxW{free_oh[i]}};
    end
  end

  // effective capacity: zero acts as one, clamp to the entry count
  assign cap_ext = CmpW'(cap_i);
  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign hit_any    = |hit_vec_q;
  assign need_evict = (item_q.cmd == CMD_PUT) && !hit_any && (CmpW'(occ_q) >= eff_cap);
  assign ins_oh     = need_evict ? vic_vec_q : free_oh;
  assign ins_idx    = need_evict ? vic_idx : free_idx;
  assign pay_idx    = hit_any ? hit_idx : ins_idx;

  // sequencer: next state, rank and occupancy updates, result word
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    rank_d    = rank_q;
    occ_d     = occ_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    key_we    = 1'b0;
    pay_we    = 1'b0;
    pay_re    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          state_d = BK_MATCH;
        end
      end
      BK_MATCH: begin
        state_d = BK_EXEC;
      end
      BK_EXEC: begin
        res_d = '0;
        if (hit_any) begin
          // promote: younger entries age by one
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && (rank_q[i] < hit_rank)) begin
              rank_d[i] = rank_q[i] + IdxW'(1);
            end
            if (hit_vec_q[i]) begin
              rank_d[i] = '0;
            end
          end
          if (item_q.cmd == CMD_PUT) begin
            pay_we    = 1'b1;
            res_d.hit = 1'b1;
            res_vld_d = 1'b1;
            state_d   = BK_IDLE;
          end else begin
            pay_re  = 1'b1;
            state_d = BK_READ;
          end
        end else if (item_q.cmd == CMD_PUT) begin
          // insert as most recent, replacing the victim when full
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && !(need_evict && vic_vec_q[i])) begin
              rank_d[i] = rank_q[i] + IdxW'(1);
            end
            if (ins_oh[i]) begin
              valid_d[i] = 1'b1;
              rank_d[i]  = '0;
            end
          end
          occ_d             = need_evict ? occ_q : occ_q + OccW'(1);
          key_we            = 1'b1;
          pay_we            = 1'b1;
          res_d.evicted     = need_evict;
          res_d.evicted_key = need_evict ? vic_key : '0;
          res_vld_d         = 1'b1;
          state_d           = BK_IDLE;
        end else begin
          // get miss: all-zero result
          res_vld_d = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      BK_READ: begin
        res_d             = '0;
        res_d.hit         = 1'b1;
        res_d.payload_out = PAY_W'(rd_data_q);
        res_vld_d         = 1'b1;
        state_d           = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      valid_q   <= '0;
      occ_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      occ_q     <= occ_d;
      res_vld_q <= res_vld_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      item_q <= item_i;
    end
    hit_vec_q <= hit_vec_d;
    vic_vec_q <= vic_vec_d;
    rank_q    <= rank_d;
    res_q     <= res_d;
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_we && ins_oh[i]) begin
        key_q[i] <= item_q.key;
      end
    end
  end

  // payload memory, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_idx] <= item_q.payload[PAYLOAD_BITS-1:0];
    end
    if (pay_re) begin
      rd_data_q <= pay_mem[pay_idx];
    end
  end

endmodule

@@ hw/rtl/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative key-to-payload cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start; the word is taken at a
//   clock edge where start is high and busy is low. A two-word queue sits
//   behind the port, so busy rises only when both queue slots are taken.
//   Result channel: result_valid_o is high for exactly one cycle with the
//   result word on rsp_o; the receiver cannot stall, so it must sample it.
//   Config channel: cfg_wdata_i writes the capacity register on
//   cfg_valid_i && cfg_ready_o; ready is always high. Write only when idle.
// Sequencing:
//   An accepted word waits in the queue until the back-end sequencer is idle.
//   The sequencer (compare, update, payload read) then runs its match and
//   execute states, and a read state for a get hit; the result word is
//   registered. It takes no new word until the last one is done.
// Reset:
//   All entries invalid, occupancy zero, capacity 16, queue empty.
//   No clearing pass is needed; the block takes words right after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
  parameter int ENTRIES      = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  lkvc_pkg::req_t             req_i,
  output logic                       busy,
  output logic                       result_valid_o,
  output lkvc_pkg::rsp_t             rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_wdata_i
);
  import lkvc_pkg::*;

  `include "lru_key_value_cache_core_assert.svh"

  localparam int OccW = $clog2(ENTRIES + 1);

  logic [CFG_W-1:0] cap_q;
  logic             item_valid, item_ready;
  q_item_t          item;
  logic [OccW-1:0]  occ;

  // capacity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lkvc_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .req_i        (req_i),
    .busy         (busy),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  lkvc_back #(
    .ENTRIES      (ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .cap_i          (cap_q),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .occ_o          (occ)
  );

  // checks
  `LKVC_ASSERT_NEXT(a_result_gap, result_valid_o, !result_valid_o, "back-to-back result words")
  `LKVC_ASSERT_NOW(a_occ_bound, 1'b1, occ <= OccW'(ENTRIES), "occupancy above entry count")
  `LKVC_ASSERT_NOW(a_evict_is_miss, result_valid_o && rsp_o.evicted, !rsp_o.hit && (rsp_o.payload_out == '0), "eviction reported on a hit")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache core testbench
// Drives get and put words through the command port and changes the capacity
// register between phases. A behavioral copy of the cache (keys, payloads,
// recency ranks, occupancy) predicts every result word, which is checked
// field by field against the block. A directed table goes first, then random
// phases over small key pools so that hits, updates and evictions are common.
// ----------------------------------------------------------------------------
module tb_top;
  import lkvc_pkg::*;

  localparam int  ENTRIES      = 16;
  localparam int  PAYLOAD_BITS = 64;
  localparam int  SETTLE       = 8;       // cycles past the last result
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  PHASES       = 8;
  localparam int  PHASE_ITEMS  = 82;
  localparam int  MAX_PRINTS   = 40;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  // one row of the directed table
  typedef struct packed {
    row_kind_e        kind;
    req_t             req;
    logic [CFG_W-1:0] cap;
    logic             typed;
    rsp_t             rsp;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  req_t             req_i;
  logic             busy;
  logic             result_valid_o;
  rsp_t             rsp_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_wdata_i;

  // cache copy used for prediction
  logic             line_valid [ENTRIES];
  logic [KEY_W-1:0] line_key   [ENTRIES];
  logic [PAY_W-1:0] line_data  [ENTRIES];
  int unsigned      line_age   [ENTRIES];
  int unsigned      fill_count;
  logic [CFG_W-1:0] capacity;

  rsp_t             pending_rsp_q[$];
  dir_row_t         dir_rows[$];
  logic [KEY_W-1:0] key_pool[24];
  int unsigned      pool_size;

  int unsigned      cycle_count;
  int unsigned      error_count;
  int unsigned      req_count;
  int unsigned      dir_count;
  int unsigned      cfg_count;
  int unsigned      hit_count;
  int unsigned      evict_count;

  lru_key_value_cache_core #(
    .ENTRIES      (ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // one line per mismatch up to MAX_PRINTS, all counted
  task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                 input logic [PAY_W-1:0] want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // Apply one access to the cache copy and return the word it produces.
  function automatic rsp_t cache_access(input req_t r);
    rsp_t        res;
    int          slot;
    int          victim;
    int          free_slot;
    int unsigned slot_age;
    int unsigned oldest;
    int unsigned cap;
    res    = '0;
    slot   = -1;
    oldest = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && line_valid[i] && line_key[i] == r.lookup_key) slot = i;

    if (slot >= 0) begin
      // hit: read or overwrite, then make it most recent
      res.hit = 1'b1;
      if (r.command == CMD_GET) res.payload_out = line_data[slot];
      else line_data[slot] = r.payload_in;
      slot_age = line_age[slot];
      for (int i = 0; i < ENTRIES; i++)
        if (line_valid[i] && line_age[i] < slot_age) line_age[i]++;
      line_age[slot] = 0;
    end else if (r.command == CMD_PUT) begin
      // zero acts as one, anything past the array size as the array size
      cap = (capacity == '0) ? 32'd1 : 32'(capacity);
      if (cap > ENTRIES) cap = ENTRIES;
      if (fill_count >= cap) begin
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (line_valid[i] && (victim < 0 || line_age[i] > oldest)) begin
            victim = i;
            oldest = line_age[i];
          end
        if (victim >= 0) begin
          res.evicted     = 1'b1;
          res.evicted_key = line_key[victim];
          line_valid[victim] = 1'b0;
          fill_count--;
        end
      end
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (free_slot < 0 && !line_valid[i]) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (line_valid[i]) line_age[i]++;
        line_valid[free_slot] = 1'b1;
        line_key[free_slot]   = r.lookup_key;
        line_data[free_slot]  = r.payload_in;
        line_age[free_slot]   = 0;
        fill_count++;
      end
    end
    return res;
  endfunction

  function automatic req_t make_req(input cmd_e cmd, input logic [KEY_W-1:0] key,
                                    input logic [PAY_W-1:0] pay);
    req_t r;
    r.command    = cmd;
    r.lookup_key = key;
    r.payload_in = pay;
    return r;
  endfunction

  function automatic rsp_t make_rsp(input logic hit, input logic [PAY_W-1:0] pay,
                                    input logic ev, input logic [KEY_W-1:0] ev_key);
    rsp_t r;
    r.hit         = hit;
    r.payload_out = pay;
    r.evicted     = ev;
    r.evicted_key = ev_key;
    return r;
  endfunction

  // table rows: a request with or without a typed-in result, or a capacity write
  function automatic dir_row_t req_row(input cmd_e cmd, input logic [KEY_W-1:0] key,
                                       input logic [PAY_W-1:0] pay, input logic typed,
                                       input rsp_t rsp);
    dir_row_t row;
    row       = '0;
    row.kind  = ROW_REQ;
    row.req   = make_req(cmd, key, pay);
    row.typed = typed;
    row.rsp   = rsp;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_W-1:0] value);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.cap  = value;
    return row;
  endfunction

  function automatic req_t random_req();
    logic [KEY_W-1:0] key;
    if ($urandom_range(0, 3) != 0) key = key_pool[$urandom_range(0, pool_size - 1)];
    else key = $urandom;
    return make_req($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, {$urandom, $urandom});
  endfunction

  // Present a word, hold it until taken, then queue its expected result.
  task automatic issue_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t predicted;
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = cache_access(r);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    req_count++;
  endtask

  // Sender gap after an accepted word; start stays high when there is none.
  task automatic sender_gap(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // capacity write, only with the block idle
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    capacity = value;
    cfg_count++;
    cfg_valid_i <= 1'b0;
  endtask

  // result check: every strobed word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("result word with nothing expected", rsp_o.payload_out, '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_o.hit !== want.hit)
          report_mismatch("hit", PAY_W'(rsp_o.hit), PAY_W'(want.hit));
        if (rsp_o.payload_out !== want.payload_out)
          report_mismatch("payload_out", rsp_o.payload_out, want.payload_out);
        if (rsp_o.evicted !== want.evicted)
          report_mismatch("evicted", PAY_W'(rsp_o.evicted), PAY_W'(want.evicted));
        if (rsp_o.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", PAY_W'($unsigned(rsp_o.evicted_key)),
                          PAY_W'($unsigned(want.evicted_key)));
        if (want.hit) hit_count++;
        if (want.evicted) evict_count++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_rsp_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_cap [PHASES];
    logic             no_idle;
    rsp_t             blank;

    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    cycle_count = 0;
    error_count = 0;
    req_count   = 0;
    dir_count   = 0;
    cfg_count   = 0;
    hit_count   = 0;
    evict_count = 0;
    blank       = '0;

    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_data[i]  = '0;
      line_age[i]   = 0;
    end
    fill_count = 0;
    capacity   = CAP_RESET;

    // directed table: extremes, update, and the capacity corner cases
    dir_rows.push_back(req_row(CMD_GET, 32'h0000_0000, '1, 1'b1, blank));
    dir_rows.push_back(req_row(CMD_PUT, 32'h8000_0000, '1, 1'b1, blank));
    dir_rows.push_back(req_row(CMD_GET, 32'h8000_0000, '0, 1'b1,
                               make_rsp(1'b1, '1, 1'b0, '0)));
    dir_rows.push_back(req_row(CMD_PUT, 32'h7fff_ffff, '0, 1'b1, blank));
    dir_rows.push_back(req_row(CMD_GET, 32'h7fff_ffff, '1, 1'b1,
                               make_rsp(1'b1, '0, 1'b0, '0)));
    dir_rows.push_back(req_row(CMD_PUT, 32'h8000_0000, 64'h5555_5555_5555_5555, 1'b1,
                               make_rsp(1'b1, '0, 1'b0, '0)));
    dir_rows.push_back(req_row(CMD_GET, 32'h8000_0000, '0, 1'b1,
                               make_rsp(1'b1, 64'h5555_5555_5555_5555, 1'b0, '0)));
    dir_rows.push_back(req_row(CMD_GET, 32'hffff_ffff, '0, 1'b1, blank));
    dir_rows.push_back(req_row(CMD_PUT, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, blank));
    // capacity zero behaves as one; occupancy three stays above it
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(req_row(CMD_PUT, 32'h0000_0001, 64'h1, 1'b1,
                               make_rsp(1'b0, '0, 1'b1, 32'h7fff_ffff)));
    dir_rows.push_back(req_row(CMD_PUT, 32'h0000_0002, 64'h2, 1'b1,
                               make_rsp(1'b0, '0, 1'b1, 32'h8000_0000)));
    dir_rows.push_back(req_row(CMD_GET, 32'hffff_ffff, '0, 1'b1,
                               make_rsp(1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0)));
    // above the array size clamps to the array size
    dir_rows.push_back(cfg_row(5'd31));
    dir_rows.push_back(req_row(CMD_PUT, 32'h0000_0003, 64'h3, 1'b1, blank));
    dir_rows.push_back(cfg_row(5'd17));
    dir_rows.push_back(req_row(CMD_GET, 32'h0000_0002, '0, 1'b0, blank));
    // capacity lowered below occupancy: one eviction per new key
    dir_rows.push_back(cfg_row(5'd1));
    dir_rows.push_back(req_row(CMD_PUT, 32'h0000_0002, 64'h22, 1'b1,
                               make_rsp(1'b1, '0, 1'b0, '0)));
    dir_rows.push_back(req_row(CMD_PUT, 32'h0000_0004, 64'h4, 1'b0, blank));
    dir_rows.push_back(req_row(CMD_PUT, 32'h0000_0005, 64'h5, 1'b0, blank));
    dir_rows.push_back(cfg_row(5'd16));
    dir_rows.push_back(req_row(CMD_GET, 32'h0000_0005, '0, 1'b0, blank));
    dir_rows.push_back(req_row(CMD_GET, 32'h0000_0004, '0, 1'b0, blank));

    phase_cap[0] = 5'd16;
    phase_cap[1] = 5'd4;
    phase_cap[2] = 5'd0;
    phase_cap[3] = 5'd31;
    phase_cap[4] = 5'd2;
    phase_cap[5] = 5'd1;
    phase_cap[6] = 5'd9;
    phase_cap[7] = 5'($urandom_range(0, 31));

    // reset
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        write_capacity(dir_rows[n].cap);
      end else begin
        issue_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].rsp);
        dir_count++;
        sender_gap($urandom_range(0, 12));
      end
    end

    // random phases, each with a fresh key pool and capacity setting
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      pool_size   = $urandom_range(4, 24);
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'hffff_ffff;
      key_pool[3] = 32'h0000_0000;
      for (int k = 4; k < 24; k++) key_pool[k] = $urandom;
      no_idle = (p % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue_request(random_req(), 1'b0, blank);
        sender_gap(no_idle ? 0 : $urandom_range(0, 12));
      end
    end

    start <= 1'b0;
    wait_drained();

    $display("Covered %0d requests (%0d from the table) over %0d capacity settings",
             req_count, dir_count, cfg_count);
    $display("Observed %0d hits and %0d evictions in %0d cycles",
             hit_count, evict_count, cycle_count);
    if (error_count == 0 && pending_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
